// ----- hw/rtl/escaped_word_tokenizer_defines.svh -----
// Assertion macros for the escaped word tokenizer
`ifndef ESCAPED_WORD_TOKENIZER_DEFINES_SVH
`define ESCAPED_WORD_TOKENIZER_DEFINES_SVH

`ifndef SYNTH
`define EWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ewt: same-cycle check failed");
`define EWT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ewt: next-cycle check failed");
`else
`define EWT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EWT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/ewt_pkg.sv -----
`default_nettype none
package ewt_pkg;

	localparam int HOLD_DEPTH_DEF = 64;
	localparam int CFG_IDX_W      = 3;

	localparam logic [7:0] ESC_CHAR = 8'h5C;

	localparam logic [CFG_IDX_W-1:0] REG_SEP_A     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_B     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_C     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_D     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COMMENT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 3'd5;

	localparam logic [7:0] SEP_A_RST   = 8'd32;
	localparam logic [7:0] SEP_B_RST   = 8'd9;
	localparam logic [7:0] SEP_C_RST   = 8'd0;
	localparam logic [7:0] SEP_D_RST   = 8'd0;
	localparam logic [7:0] COMMENT_RST = 8'd59;
	localparam logic [5:0] MAX_LEN_RST = 6'd63;

	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_END_WORD = 2'd1,
		KIND_END_LINE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_END_WORD,
		ACT_EOL_WORD,
		ACT_EOL,
		ACT_CHAR,
		ACT_FLUSH
	} act_t;

	typedef enum logic [2:0] {
		PUSH_IN_CHAR,
		PUSH_MEM,
		PUSH_HELD_CHAR,
		PUSH_END_WORD,
		PUSH_END_LINE
	} push_sel_t;

	typedef struct packed {
		logic      accept;
		logic      push;
		push_sel_t push_sel;
		logic      rd_first;
		logic      rd_next;
	} ewt_cmd_t;

	typedef struct packed {
		act_t act;
		logic q_full;
		logic flush_last;
	} ewt_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ewt_if.sv -----
`default_nettype none
interface ewt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       line_done;

	modport source (output valid, ch, line_done, input ready);
	modport sink   (input valid, ch, line_done, output ready);
endinterface

interface ewt_token_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [1:0] kind;

	modport source (output valid, out_char, kind, input ready);
	modport sink   (input valid, out_char, kind, output ready);
endinterface

interface ewt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ewt_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ewt_datapath.sv -----
`default_nettype none
`include "escaped_word_tokenizer_defines.svh"
module ewt_datapath #(
	parameter int HOLD_DEPTH = ewt_pkg::HOLD_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ewt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire logic [7:0]                     in_ch,
	input  wire logic                           in_line_done,
	input  wire ewt_pkg::ewt_cmd_t              cmd,
	output ewt_pkg::ewt_status_t                status,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [7:0]                          out_char,
	output logic [1:0]                          out_kind
);
	localparam int HCW = $clog2(HOLD_DEPTH + 1);
	localparam int AW  = $clog2(HOLD_DEPTH);

	logic [7:0] sep_a_q, sep_b_q, sep_c_q, sep_d_q, comment_q;
	logic [5:0] max_len_q;

	logic           esc_q;
	logic           skip_q;
	logic [5:0]     wc_q;
	logic [HCW-1:0] held_q;
	logic [HCW-1:0] flush_n_q;
	logic [HCW-1:0] idx_q;
	logic [7:0]     char_q;
	logic [7:0]     rdata_q;
	logic [7:0]     mem [HOLD_DEPTH];

	logic [7:0] q_char_q [2];
	logic [1:0] q_kind_q [2];
	logic       q_wr_q, q_rd_q;
	logic [1:0] q_cnt_q;

	logic is_sep, is_cmt, is_bs, is_white, overflow, held_room;
	logic pop;
	logic [7:0] push_char;
	logic [1:0] push_kind;
	logic [AW-1:0] rd_addr;
	logic [HCW-1:0] idx_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_a_q   <= ewt_pkg::SEP_A_RST;
			sep_b_q   <= ewt_pkg::SEP_B_RST;
			sep_c_q   <= ewt_pkg::SEP_C_RST;
			sep_d_q   <= ewt_pkg::SEP_D_RST;
			comment_q <= ewt_pkg::COMMENT_RST;
			max_len_q <= ewt_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ewt_pkg::REG_SEP_A:   sep_a_q   <= cfg_data;
				ewt_pkg::REG_SEP_B:   sep_b_q   <= cfg_data;
				ewt_pkg::REG_SEP_C:   sep_c_q   <= cfg_data;
				ewt_pkg::REG_SEP_D:   sep_d_q   <= cfg_data;
				ewt_pkg::REG_COMMENT: comment_q <= cfg_data;
				ewt_pkg::REG_MAX_LEN: max_len_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign is_sep = (sep_a_q != 8'd0 && sep_a_q == in_ch) ||
	                (sep_b_q != 8'd0 && sep_b_q == in_ch) ||
	                (sep_c_q != 8'd0 && sep_c_q == in_ch) ||
	                (sep_d_q != 8'd0 && sep_d_q == in_ch);
	assign is_cmt    = comment_q != 8'd0 && comment_q == in_ch;
	assign is_bs     = in_ch == ewt_pkg::ESC_CHAR;
	assign is_white  = in_ch == 8'h20 || (in_ch >= 8'h09 && in_ch <= 8'h0D);
	assign overflow  = wc_q >= max_len_q;
	assign held_room = held_q < HCW'(HOLD_DEPTH);
	assign idx_inc   = idx_q + 1'b1;

	always_comb begin
		status.q_full     = q_cnt_q == 2'd2;
		status.flush_last = idx_inc == flush_n_q;
		status.act        = ewt_pkg::ACT_NONE;
		if (in_line_done) begin
			status.act = (!skip_q && wc_q != 6'd0) ? ewt_pkg::ACT_EOL_WORD : ewt_pkg::ACT_EOL;
		end else if (skip_q) begin
			status.act = ewt_pkg::ACT_NONE;
		end else if (!esc_q && is_sep) begin
			status.act = ewt_pkg::ACT_END_WORD;
		end else if (!esc_q && is_cmt) begin
			status.act = (wc_q != 6'd0) ? ewt_pkg::ACT_END_WORD : ewt_pkg::ACT_NONE;
		end else if (!esc_q && is_bs) begin
			status.act = ewt_pkg::ACT_NONE;
		end else if (overflow) begin
			status.act = ewt_pkg::ACT_END_WORD;
		end else if (is_white) begin
			status.act = ewt_pkg::ACT_NONE;
		end else if (held_q != '0) begin
			status.act = ewt_pkg::ACT_FLUSH;
		end else begin
			status.act = ewt_pkg::ACT_CHAR;
		end
	end

	// word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			skip_q <= 1'b0;
			wc_q   <= '0;
			held_q <= '0;
		end else if (cmd.accept) begin
			if (in_line_done) begin
				esc_q  <= 1'b0;
				skip_q <= 1'b0;
				wc_q   <= '0;
				held_q <= '0;
			end else if (skip_q) begin
				esc_q <= esc_q;
			end else if (!esc_q && is_sep) begin
				wc_q   <= '0;
				held_q <= '0;
			end else if (!esc_q && is_cmt) begin
				wc_q   <= '0;
				held_q <= '0;
				skip_q <= 1'b1;
			end else if (!esc_q && is_bs) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				if (overflow) begin
					wc_q   <= '0;
					held_q <= '0;
				end else begin
					wc_q <= wc_q + 6'd1;
					if (is_white) begin
						if (held_room) begin
							held_q <= held_q + 1'b1;
						end
					end else begin
						held_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q    <= in_ch;
			flush_n_q <= held_q;
		end
	end

	// held whitespace store
	always_ff @(posedge clk) begin
		if (cmd.accept && !in_line_done && !skip_q && !(!esc_q && (is_sep || is_cmt || is_bs))
		    && !overflow && is_white && held_room) begin
			mem[held_q[AW-1:0]] <= in_ch;
		end
	end

	assign rd_addr = cmd.rd_first ? '0 : idx_inc[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.rd_first || cmd.rd_next) begin
			rdata_q <= mem[rd_addr];
			idx_q   <= cmd.rd_first ? '0 : idx_inc;
		end
	end

	always_comb begin
		push_char = 8'd0;
		push_kind = ewt_pkg::KIND_CHAR;
		case (cmd.push_sel)
			ewt_pkg::PUSH_IN_CHAR:   push_char = in_ch;
			ewt_pkg::PUSH_MEM:       push_char = rdata_q;
			ewt_pkg::PUSH_HELD_CHAR: push_char = char_q;
			ewt_pkg::PUSH_END_WORD:  push_kind = ewt_pkg::KIND_END_WORD;
			ewt_pkg::PUSH_END_LINE:  push_kind = ewt_pkg::KIND_END_LINE;
			default:                 push_kind = ewt_pkg::KIND_CHAR;
		endcase
	end

	// two-entry result queue
	assign out_valid = q_cnt_q != 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_char  = q_char_q[q_rd_q];
	assign out_kind  = q_kind_q[q_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= 1'b0;
			q_rd_q  <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (cmd.push) begin
				q_wr_q <= ~q_wr_q;
			end
			if (pop) begin
				q_rd_q <= ~q_rd_q;
			end
			q_cnt_q <= q_cnt_q + {1'b0, cmd.push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			q_char_q[q_wr_q] <= push_char;
			q_kind_q[q_wr_q] <= push_kind;
		end
	end

	`EWT_ASSERT_IMP(a_q_cnt_range, clk, arst_n, 1'b1, q_cnt_q <= 2'd2)
	`EWT_ASSERT_IMP(a_held_in_word, clk, arst_n, 1'b1, {{(8 - HCW){1'b0}}, held_q} <= {2'b00, wc_q})
	`EWT_ASSERT_IMP(a_rd_next_in_range, clk, arst_n, cmd.rd_next, !status.flush_last)
endmodule
`default_nettype wire

// ----- hw/rtl/ewt_ctrl.sv -----
`default_nettype none
`include "escaped_word_tokenizer_defines.svh"
module ewt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ewt_pkg::ewt_status_t status,
	output ewt_pkg::ewt_cmd_t         cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_EOL,
		S_FLUSH_RD,
		S_FLUSH_PUT,
		S_PUT_CHAR
	} state_t;

	state_t state_q, state_d;

	assign in_ready = state_q == S_IDLE && !status.q_full;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.push     = 1'b0;
		cmd.push_sel = ewt_pkg::PUSH_IN_CHAR;
		cmd.rd_first = 1'b0;
		cmd.rd_next  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.accept = 1'b1;
					unique case (status.act)
						ewt_pkg::ACT_END_WORD: begin
							cmd.push     = 1'b1;
							cmd.push_sel = ewt_pkg::PUSH_END_WORD;
						end
						ewt_pkg::ACT_EOL_WORD: begin
							cmd.push     = 1'b1;
							cmd.push_sel = ewt_pkg::PUSH_END_WORD;
							state_d      = S_EOL;
						end
						ewt_pkg::ACT_EOL: begin
							cmd.push     = 1'b1;
							cmd.push_sel = ewt_pkg::PUSH_END_LINE;
						end
						ewt_pkg::ACT_CHAR: begin
							cmd.push     = 1'b1;
							cmd.push_sel = ewt_pkg::PUSH_IN_CHAR;
						end
						ewt_pkg::ACT_FLUSH: state_d = S_FLUSH_RD;
						default: ;
					endcase
				end
			end
			S_EOL: begin
				if (!status.q_full) begin
					cmd.push     = 1'b1;
					cmd.push_sel = ewt_pkg::PUSH_END_LINE;
					state_d      = S_IDLE;
				end
			end
			S_FLUSH_RD: begin
				cmd.rd_first = 1'b1;
				state_d      = S_FLUSH_PUT;
			end
			S_FLUSH_PUT: begin
				if (!status.q_full) begin
					cmd.push     = 1'b1;
					cmd.push_sel = ewt_pkg::PUSH_MEM;
					if (status.flush_last) begin
						state_d = S_PUT_CHAR;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			S_PUT_CHAR: begin
				if (!status.q_full) begin
					cmd.push     = 1'b1;
					cmd.push_sel = ewt_pkg::PUSH_HELD_CHAR;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`EWT_ASSERT_IMP(a_push_has_room, clk, arst_n, cmd.push, !status.q_full)
	`EWT_ASSERT_NXT(a_flush_enters_read, clk, arst_n,
		cmd.accept && status.act == ewt_pkg::ACT_FLUSH, state_q == S_FLUSH_RD)
	`EWT_ASSERT_NXT(a_read_then_put, clk, arst_n, state_q == S_FLUSH_RD, state_q == S_FLUSH_PUT)
endmodule
`default_nettype wire

// ----- hw/rtl/escaped_word_tokenizer.sv -----
// Escaped word tokenizer.
// chars:  input transactions, one character or an end-of-line flag each.
// tokens: result transactions, a word character, an end of word or an end of line.
// cfg:    register writes (separators, comment mark, maximum word length);
//         always ready, write only while the block is idle.
// A result is registered in the result queue before it appears on tokens.
// An ordinary character, separator or end of line is handled in its accepting
// cycle; an end of line that also ends a word pushes the end of line from S_EOL.
// A character that releases held whitespace passes through the accepting cycle,
// S_FLUSH_RD to start the registered read of the held store, S_FLUSH_PUT for
// each held character and S_PUT_CHAR for the character itself; every push
// waits while the queue is full.
// Results pass through a two-entry queue, so chars keeps flowing while one
// result waits; when tokens stalls and the queue fills, chars.ready drops
// and the block holds its place until the queue drains.
// Reset restores the register defaults and clears the word state; the held
// store needs no clearing pass.
`default_nettype none
module escaped_word_tokenizer #(
	parameter int HOLD_DEPTH = ewt_pkg::HOLD_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ewt_char_if.sink    chars,
	ewt_token_if.source tokens,
	ewt_cfg_if.sink     cfg
);
	ewt_pkg::ewt_cmd_t    cmd;
	ewt_pkg::ewt_status_t status;

	assign cfg.ready = 1'b1;

	ewt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ewt_datapath #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.in_ch        (chars.ch),
		.in_line_done (chars.line_done),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (tokens.valid),
		.out_ready    (tokens.ready),
		.out_char     (tokens.out_char),
		.out_kind     (tokens.kind)
	);
endmodule
`default_nettype wire
